// ----- rtl/staged_pd_position_controller_core_macros.svh -----
// ----------------------------------------------------------------------------
// staged pd position controller assertion macros
// short wrappers for the concurrent checks of the controller core
// ----------------------------------------------------------------------------
`ifndef STAGED_PD_POSITION_CONTROLLER_CORE_MACROS_SVH
`define STAGED_PD_POSITION_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spdc check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define SPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spdc check failed: next-cycle implication");

`endif

// ----- rtl/spdc_pkg.sv -----
// ----------------------------------------------------------------------------
// spdc_pkg
// shared types, codes and reset constants of the staged pd position controller
// ----------------------------------------------------------------------------
package spdc_pkg;

   localparam int POS_WIDTH_DEFAULT = 16;

   localparam int GAIN_WIDTH   = 10;
   localparam int COORD_WIDTH  = 16;
   localparam int CAP_WIDTH    = 7;
   localparam int DRIVE_WIDTH  = 8;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int Q_SHIFT      = 8;

   // register reset values
   localparam logic [GAIN_WIDTH-1:0]         PROP_GAIN_RESET   = 10'd218;
   localparam logic [GAIN_WIDTH-1:0]         DERIV_GAIN_RESET  = 10'd77;
   localparam logic signed [COORD_WIDTH-1:0] RAISED_TGT_RESET  = -16'sd400;
   localparam logic signed [COORD_WIDTH-1:0] PLACE_TGT_RESET   = -16'sd4850;
   localparam logic signed [COORD_WIDTH-1:0] FIRST_EDGE_RESET  = -16'sd2000;
   localparam logic signed [COORD_WIDTH-1:0] SECOND_EDGE_RESET = -16'sd3800;
   localparam logic [CAP_WIDTH-1:0]          MIDDLE_CAP_RESET  = 7'd90;
   localparam logic [CAP_WIDTH-1:0]          SLOW_CAP_RESET    = 7'd50;

   localparam logic [CAP_WIDTH-1:0]          CAP_FULL     = 7'd127;
   localparam logic signed [DRIVE_WIDTH-1:0] DEADBAND_HI  = 8'sd10;
   localparam logic signed [DRIVE_WIDTH-1:0] DEADBAND_LO  = -8'sd10;
   localparam logic signed [DRIVE_WIDTH-1:0] JOY_MOST_NEG = -8'sd128;
   localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MAX    = 8'sd127;

   typedef enum logic [1:0] {
      MODE_LOWERED = 2'd0,
      MODE_RAISED  = 2'd1,
      MODE_HOLD    = 2'd2
   } mode_type;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_DERIV_GAIN  = 3'd1,
      REG_RAISED_TGT  = 3'd2,
      REG_PLACE_TGT   = 3'd3,
      REG_FIRST_EDGE  = 3'd4,
      REG_SECOND_EDGE = 3'd5,
      REG_MIDDLE_CAP  = 3'd6,
      REG_SLOW_CAP    = 3'd7
   } reg_index_type;

   // decisions of the target unit handed to the top level
   typedef struct packed {
      mode_type               mode_next;
      logic                   place_next;
      logic                   use_joy;
      logic [CAP_WIDTH-1:0]   cap;
   } ctrl_type;

endpackage

// ----- rtl/spdc_target.sv -----
// ----------------------------------------------------------------------------
// spdc_target
// mode sequencing, target selection, staged speed cap and placing end
// ----------------------------------------------------------------------------
module spdc_target #(
   parameter int POS_WIDTH = spdc_pkg::POS_WIDTH_DEFAULT
) (
   input  logic signed [POS_WIDTH-1:0]               position,
   input  logic signed [spdc_pkg::DRIVE_WIDTH-1:0]   joystick,
   input  logic                                      limit_pressed,
   input  logic                                      toggle_pressed,
   input  logic                                      place_held,
   input  spdc_pkg::mode_type                        mode,
   input  logic                                      place_active,
   input  logic signed [spdc_pkg::COORD_WIDTH-1:0]   raised_target,
   input  logic signed [spdc_pkg::COORD_WIDTH-1:0]   place_target,
   input  logic signed [spdc_pkg::COORD_WIDTH-1:0]   first_stage_edge,
   input  logic signed [spdc_pkg::COORD_WIDTH-1:0]   second_stage_edge,
   input  logic [spdc_pkg::CAP_WIDTH-1:0]            middle_cap,
   input  logic [spdc_pkg::CAP_WIDTH-1:0]            slow_cap,
   output logic signed [((POS_WIDTH > spdc_pkg::COORD_WIDTH) ? POS_WIDTH :
                         spdc_pkg::COORD_WIDTH)-1:0] pd_target,
   output logic signed [spdc_pkg::COORD_WIDTH-1:0]   final_target,
   output logic signed [spdc_pkg::DRIVE_WIDTH-1:0]   joy_drive,
   output spdc_pkg::ctrl_type                        ctrl
);
   localparam int TW = (POS_WIDTH > spdc_pkg::COORD_WIDTH) ? POS_WIDTH :
                       spdc_pkg::COORD_WIDTH;

   logic signed [TW-1:0] pos_ext, rt_ext, pt_ext, e1_ext, e2_ext;
   logic signed [TW-1:0] tgt_mode, tgt_place, tgt_joy, eff_pos, tgt_end;
   spdc_pkg::mode_type   mode_tog, mode_place, mode_end;
   logic                 place_set, place_end, joy_in_band;
   logic [spdc_pkg::CAP_WIDTH-1:0] cap_sel;
   logic                 use_joy;

   assign pos_ext = TW'(position);
   assign rt_ext  = TW'(raised_target);
   assign pt_ext  = TW'(place_target);
   assign e1_ext  = TW'(first_stage_edge);
   assign e2_ext  = TW'(second_stage_edge);

   // toggle first, then the target the mode asks for
   always_comb begin
      case (mode)
         spdc_pkg::MODE_LOWERED: begin
            mode_tog = toggle_pressed ? spdc_pkg::MODE_RAISED : spdc_pkg::MODE_LOWERED;
         end
         default: begin
            mode_tog = toggle_pressed ? spdc_pkg::MODE_LOWERED : mode;
         end
      endcase
      case (mode_tog)
         spdc_pkg::MODE_LOWERED: tgt_mode = '0;
         spdc_pkg::MODE_RAISED:  tgt_mode = rt_ext;
         default:                tgt_mode = pos_ext;
      endcase
   end

   // place button overrides mode and target
   always_comb begin
      if (place_held) begin
         place_set  = 1'b1;
         mode_place = spdc_pkg::MODE_HOLD;
         tgt_place  = pt_ext;
      end else begin
         place_set  = place_active;
         mode_place = mode_tog;
         tgt_place  = tgt_mode;
      end
   end

   // staged speed cap while placing
   always_comb begin
      if (place_set && pos_ext >= e1_ext) begin
         cap_sel = spdc_pkg::CAP_FULL;
      end else if (place_set && pos_ext < e1_ext && pos_ext > e2_ext) begin
         cap_sel = middle_cap;
      end else if (place_set && pos_ext < e2_ext && pos_ext >= pt_ext) begin
         cap_sel = slow_cap;
      end else begin
         cap_sel = spdc_pkg::CAP_FULL;
      end
   end

   // operator override and home limit
   always_comb begin
      joy_in_band = (joystick < spdc_pkg::DEADBAND_HI) && (joystick > spdc_pkg::DEADBAND_LO);
      mode_end    = mode_place;
      if (!limit_pressed) begin
         eff_pos = pos_ext;
         use_joy = !joy_in_band;
         tgt_joy = joy_in_band ? tgt_place : pos_ext;
      end else begin
         eff_pos = '0;
         tgt_joy = '0;
         use_joy = (joystick > spdc_pkg::DEADBAND_HI);
         if (joystick > spdc_pkg::DEADBAND_HI) begin
            mode_end = spdc_pkg::MODE_HOLD;
         end
      end
   end

   // placing ends once below the place target
   always_comb begin
      place_end = (eff_pos < pt_ext);
      tgt_end   = place_end ? eff_pos : tgt_joy;
   end

   assign joy_drive    = (joystick == spdc_pkg::JOY_MOST_NEG) ? spdc_pkg::DRIVE_MAX :
                         -joystick;
   assign pd_target    = tgt_place;
   assign final_target = tgt_end[spdc_pkg::COORD_WIDTH-1:0];
   assign ctrl         = '{mode_next:  mode_end,
                           place_next: place_set && !place_end,
                           use_joy:    use_joy,
                           cap:        cap_sel};

endmodule

// ----- rtl/spdc_pd.sv -----
// ----------------------------------------------------------------------------
// spdc_pd
// pd drive from position error, q8 gains truncated toward zero, clamped to cap
// ----------------------------------------------------------------------------
module spdc_pd #(
   parameter int POS_WIDTH = spdc_pkg::POS_WIDTH_DEFAULT
) (
   input  logic signed [((POS_WIDTH > spdc_pkg::COORD_WIDTH) ? POS_WIDTH :
                         spdc_pkg::COORD_WIDTH)-1:0] target,
   input  logic signed [POS_WIDTH-1:0]               position,
   input  logic signed [((POS_WIDTH > spdc_pkg::COORD_WIDTH) ? POS_WIDTH :
                         spdc_pkg::COORD_WIDTH):0]   prev_error,
   input  logic [spdc_pkg::GAIN_WIDTH-1:0]           prop_gain_q8,
   input  logic [spdc_pkg::GAIN_WIDTH-1:0]           deriv_gain_q8,
   input  logic [spdc_pkg::CAP_WIDTH-1:0]            cap,
   output logic signed [((POS_WIDTH > spdc_pkg::COORD_WIDTH) ? POS_WIDTH :
                         spdc_pkg::COORD_WIDTH):0]   error,
   output logic signed [spdc_pkg::DRIVE_WIDTH-1:0]   pd_drive
);
   localparam int TW  = (POS_WIDTH > spdc_pkg::COORD_WIDTH) ? POS_WIDTH :
                        spdc_pkg::COORD_WIDTH;
   localparam int EW  = TW + 1;
   localparam int DW  = EW + 1;
   localparam int PRW = DW + spdc_pkg::GAIN_WIDTH + 1;

   logic signed [DW-1:0]  diff;
   logic signed [spdc_pkg::GAIN_WIDTH:0] kp, kd;
   logic signed [PRW-1:0] prod_p, prod_d, quot_p, quot_d, sum, cap_pos, cap_neg;
   logic [PRW-1:0]        bias_p, bias_d;

   assign error = EW'(target) - EW'(position);
   assign diff  = DW'(error) - DW'(prev_error);
   assign kp    = $signed({1'b0, prop_gain_q8});
   assign kd    = $signed({1'b0, deriv_gain_q8});

   assign prod_p = PRW'(kp) * PRW'(error);
   assign prod_d = PRW'(kd) * PRW'(diff);

   // add 255 to negatives so the shift rounds toward zero
   assign bias_p = {{(PRW-spdc_pkg::Q_SHIFT){1'b0}}, {spdc_pkg::Q_SHIFT{prod_p[PRW-1]}}};
   assign bias_d = {{(PRW-spdc_pkg::Q_SHIFT){1'b0}}, {spdc_pkg::Q_SHIFT{prod_d[PRW-1]}}};
   assign quot_p = (prod_p + $signed(bias_p)) >>> spdc_pkg::Q_SHIFT;
   assign quot_d = (prod_d + $signed(bias_d)) >>> spdc_pkg::Q_SHIFT;
   assign sum    = quot_p + quot_d;

   assign cap_pos = PRW'($signed({1'b0, cap}));
   assign cap_neg = -cap_pos;

   always_comb begin
      if (sum > cap_pos) begin
         pd_drive = spdc_pkg::DRIVE_WIDTH'(cap_pos);
      end else if (sum < cap_neg) begin
         pd_drive = spdc_pkg::DRIVE_WIDTH'(cap_neg);
      end else begin
         pd_drive = spdc_pkg::DRIVE_WIDTH'(sum);
      end
   end

endmodule

// ----- rtl/staged_pd_position_controller_core.sv -----
// ----------------------------------------------------------------------------
// staged_pd_position_controller_core
// staged pd position controller with output clamp and operator override
// ----------------------------------------------------------------------------
// One control tick goes in per req beat and one result beat comes out per tick,
// in order. A tick is captured in an input register, passes through a single
// combinational pass (mode and target choice, staged cap, two gain products,
// clamp, joystick override) and lands in the result register, where the mode,
// place flag and previous error are updated in the same edge. A tick thus passes
// the input register and then the result register before rsp_tvalid rises. A new
// tick can be taken every cycle while results are drained; while a result waits
// on rsp_tready the input register takes a beat only if it is empty. The pd pass
// is combinational; its longest path is the gain multiply followed by the sum
// and clamp against the cap. Configuration registers are written through the
// csr port and reset to their documented values; the user must write them only
// while the block is idle, and the block itself does not enforce this.
`include "staged_pd_position_controller_core_macros.svh"

module staged_pd_position_controller_core #(
   parameter int POS_WIDTH = spdc_pkg::POS_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   // control tick beat
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // position, joystick, limit_pressed, toggle_pressed, place_held (low bit up)
   input  logic [((POS_WIDTH + 11 + 7) / 8) * 8 - 1:0] req_tdata,
   // result beat
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // motor_drive, zero_encoder, current_target, placing (low bit up)
   output logic [31:0]                          rsp_tdata,
   // register write port
   input  logic                                 csr_we,
   input  logic [spdc_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [spdc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   localparam int TW = (POS_WIDTH > spdc_pkg::COORD_WIDTH) ? POS_WIDTH :
                       spdc_pkg::COORD_WIDTH;
   localparam int EW = TW + 1;
   localparam int JOY_LSB = POS_WIDTH;
   localparam int LIM_BIT = POS_WIDTH + spdc_pkg::DRIVE_WIDTH;

   // configuration registers
   logic [spdc_pkg::GAIN_WIDTH-1:0]         prop_gain_ff, deriv_gain_ff;
   logic signed [spdc_pkg::COORD_WIDTH-1:0] raised_tgt_ff, place_tgt_ff;
   logic signed [spdc_pkg::COORD_WIDTH-1:0] first_edge_ff, second_edge_ff;
   logic [spdc_pkg::CAP_WIDTH-1:0]          middle_cap_ff, slow_cap_ff;

   // input stage
   logic                                    in_valid_ff, in_valid_in;
   logic signed [POS_WIDTH-1:0]             pos_ff;
   logic signed [spdc_pkg::DRIVE_WIDTH-1:0] joy_ff;
   logic                                    lim_ff, tog_ff, plc_ff;

   // controller state
   spdc_pkg::mode_type                      mode_ff;
   logic                                    place_ff;
   logic signed [EW-1:0]                    prev_err_ff;

   // result stage
   logic                                    out_valid_ff, out_valid_in;
   logic signed [spdc_pkg::DRIVE_WIDTH-1:0] drive_ff, drive_in;
   logic                                    zero_ff;
   logic signed [spdc_pkg::COORD_WIDTH-1:0] target_ff;
   logic                                    placing_ff;

   logic                                    req_beat, advance;

   logic signed [TW-1:0]                    pd_target;
   logic signed [spdc_pkg::COORD_WIDTH-1:0] final_target;
   logic signed [spdc_pkg::DRIVE_WIDTH-1:0] joy_drive, pd_drive;
   logic signed [EW-1:0]                    error;
   spdc_pkg::ctrl_type                      ctrl;

   // handshake: the input stage moves on whenever the result register is free
   // or is being drained in the same cycle
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_beat     = req_tvalid && req_tready;
   assign in_valid_in  = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= spdc_pkg::PROP_GAIN_RESET;
         deriv_gain_ff  <= spdc_pkg::DERIV_GAIN_RESET;
         raised_tgt_ff  <= spdc_pkg::RAISED_TGT_RESET;
         place_tgt_ff   <= spdc_pkg::PLACE_TGT_RESET;
         first_edge_ff  <= spdc_pkg::FIRST_EDGE_RESET;
         second_edge_ff <= spdc_pkg::SECOND_EDGE_RESET;
         middle_cap_ff  <= spdc_pkg::MIDDLE_CAP_RESET;
         slow_cap_ff    <= spdc_pkg::SLOW_CAP_RESET;
      end else if (csr_we) begin
         case (spdc_pkg::reg_index_type'(csr_addr))
            spdc_pkg::REG_PROP_GAIN:   prop_gain_ff   <= csr_wdata[spdc_pkg::GAIN_WIDTH-1:0];
            spdc_pkg::REG_DERIV_GAIN:  deriv_gain_ff  <= csr_wdata[spdc_pkg::GAIN_WIDTH-1:0];
            spdc_pkg::REG_RAISED_TGT:  raised_tgt_ff  <= $signed(csr_wdata);
            spdc_pkg::REG_PLACE_TGT:   place_tgt_ff   <= $signed(csr_wdata);
            spdc_pkg::REG_FIRST_EDGE:  first_edge_ff  <= $signed(csr_wdata);
            spdc_pkg::REG_SECOND_EDGE: second_edge_ff <= $signed(csr_wdata);
            spdc_pkg::REG_MIDDLE_CAP:  middle_cap_ff  <= csr_wdata[spdc_pkg::CAP_WIDTH-1:0];
            spdc_pkg::REG_SLOW_CAP:    slow_cap_ff    <= csr_wdata[spdc_pkg::CAP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input register: control part
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // input register: tick fields, held while stalled
   always_ff @(posedge clock) begin
      if (req_beat) begin
         pos_ff <= $signed(req_tdata[POS_WIDTH-1:0]);
         joy_ff <= $signed(req_tdata[JOY_LSB +: spdc_pkg::DRIVE_WIDTH]);
         lim_ff <= req_tdata[LIM_BIT];
         tog_ff <= req_tdata[LIM_BIT + 1];
         plc_ff <= req_tdata[LIM_BIT + 2];
      end
   end

   // mode, target, cap and override decisions
   spdc_target #(
      .POS_WIDTH (POS_WIDTH)
   ) u_target (
      .position          (pos_ff),
      .joystick          (joy_ff),
      .limit_pressed     (lim_ff),
      .toggle_pressed    (tog_ff),
      .place_held        (plc_ff),
      .mode              (mode_ff),
      .place_active      (place_ff),
      .raised_target     (raised_tgt_ff),
      .place_target      (place_tgt_ff),
      .first_stage_edge  (first_edge_ff),
      .second_stage_edge (second_edge_ff),
      .middle_cap        (middle_cap_ff),
      .slow_cap          (slow_cap_ff),
      .pd_target         (pd_target),
      .final_target      (final_target),
      .joy_drive         (joy_drive),
      .ctrl              (ctrl)
   );

   // pd term with staged clamp
   spdc_pd #(
      .POS_WIDTH (POS_WIDTH)
   ) u_pd (
      .target        (pd_target),
      .position      (pos_ff),
      .prev_error    (prev_err_ff),
      .prop_gain_q8  (prop_gain_ff),
      .deriv_gain_q8 (deriv_gain_ff),
      .cap           (ctrl.cap),
      .error         (error),
      .pd_drive      (pd_drive)
   );

   // operator stick wins outside the deadband; with a pressed limit only when pushed above it
   assign drive_in = ctrl.use_joy ? joy_drive : pd_drive;

   // controller state moves on with each tick handed to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= spdc_pkg::MODE_LOWERED;
         place_ff    <= 1'b0;
         prev_err_ff <= '0;
      end else if (advance) begin
         mode_ff     <= ctrl.mode_next;
         place_ff    <= ctrl.place_next;
         prev_err_ff <= error;
      end
   end

   // result register: control part
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // result register: fields
   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff   <= drive_in;
         zero_ff    <= lim_ff;
         target_ff  <= final_target;
         placing_ff <= ctrl.place_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, placing_ff, target_ff, zero_ff, drive_ff};

   // a stalled tick stays in the input register
   `SPDC_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(pos_ff))
   // every tick handed on shows up as a result beat
   `SPDC_ASSERT_NEXT(a_out_load, clock, reset, advance, out_valid_ff)
   // state only moves when a tick is handed on
   `SPDC_ASSERT_NEXT(a_state_hold, clock, reset, !advance, $stable(prev_err_ff) && $stable(mode_ff))
   // a pressed limit always leaves the target at home
   `SPDC_ASSERT_IMPLY(a_home_target, clock, reset, out_valid_ff && zero_ff, target_ff == 16'sd0)

endmodule
